@@ rtl/core/mwcs_pkg.sv @@
`default_nettype none

package mwcs_pkg;

    // text buffer depth and alphabet size (alphabet kept a power of two)
    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 128;

    localparam int SYM_W   = 7;                        // input symbol field
    localparam int ALPHA_W = $clog2(ALPHABET);         // need-count index
    localparam int POS_W   = $clog2(MAX_TEXT);         // text address
    localparam int LEN_W   = $clog2(MAX_TEXT + 2);     // edges, lengths, missing
    localparam int NEED_W  = LEN_W + 1;                // signed need count

    localparam logic [LEN_W-1:0] LEN_NONE = '1;

    // stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // result field positions in m_tdata
    localparam int OUT_FOUND_LSB = 0;
    localparam int OUT_START_LSB = 1;
    localparam int OUT_LEN_LSB   = OUT_START_LSB + POS_W;
    localparam int OUT_OVF_LSB   = OUT_LEN_LSB + LEN_W;
    localparam int OUT_USED_W    = OUT_OVF_LSB + 1;

    // item kind carried on tuser
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef struct packed {
        logic latch_item;    // take the input transfer, read need[symbol]
        logic store_text;    // write symbol at right edge
        logic set_lost;      // text dropped, buffer full
        logic pat_inc;       // raise need of pattern symbol
        logic txt_dec;       // lower need of text symbol
        logic sh_txt_rd;     // read symbol at left edge, record best window
        logic sh_need_rd;    // read need of outgoing symbol
        logic sh_wr;         // raise need of outgoing symbol, advance left edge
        logic finish;        // load result, clear job
    } mwcs_cmd_t;

    typedef struct packed {
        logic room;          // buffer not full
        logic item_func;
        logic item_last;
        logic item_stored;
        logic pattern_ok;
        logic missing_zero;
        logic dec_covers;    // decrement completes the cover
        logic sh_continue;   // window still covers after this advance
        logic out_free;      // result register can take a new result
    } mwcs_status_t;

endpackage

`default_nettype wire

@@ rtl/core/mwcs_ctrl.sv @@
`default_nettype none

module mwcs_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    input  wire                    s_tuser,
    output logic                   s_tready,
    input  mwcs_pkg::mwcs_status_t status,
    output mwcs_pkg::mwcs_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPDATE = 6'b000010,
        ST_SH_TXT = 6'b000100,
        ST_SH_NRD = 6'b001000,
        ST_SH_WR  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    state_t end_state;

    assign s_tready  = (state_reg == ST_IDLE);
    assign end_state = status.item_last ? ST_FINISH : ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_item = 1'b1;
                    cmd.store_text = (s_tuser == mwcs_pkg::FUNC_TEXT) && status.room;
                    cmd.set_lost   = (s_tuser == mwcs_pkg::FUNC_TEXT) && !status.room;
                    state_next     = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (status.item_func == mwcs_pkg::FUNC_PATTERN) begin
                    cmd.pat_inc = status.pattern_ok;
                    state_next  = ST_IDLE;      // last ignored on a pattern item
                end else if (!status.item_stored || status.missing_zero) begin
                    state_next = end_state;
                end else begin
                    cmd.txt_dec = 1'b1;
                    state_next  = status.dec_covers ? ST_SH_TXT : end_state;
                end
            end
            ST_SH_TXT: begin
                cmd.sh_txt_rd = 1'b1;
                state_next    = ST_SH_NRD;
            end
            ST_SH_NRD: begin
                cmd.sh_need_rd = 1'b1;
                state_next     = ST_SH_WR;
            end
            ST_SH_WR: begin
                cmd.sh_wr  = 1'b1;
                state_next = status.sh_continue ? ST_SH_TXT : end_state;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mwcs_datapath.sv @@
`default_nettype none

module mwcs_datapath (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  [mwcs_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire                                 s_tuser,
    input  wire                                 s_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [mwcs_pkg::M_DATA_W-1:0]       m_tdata,
    input  mwcs_pkg::mwcs_cmd_t                 cmd,
    output mwcs_pkg::mwcs_status_t              status
);

    localparam int ALPHA_W = mwcs_pkg::ALPHA_W;
    localparam int POS_W   = mwcs_pkg::POS_W;
    localparam int LEN_W   = mwcs_pkg::LEN_W;
    localparam int NEED_W  = mwcs_pkg::NEED_W;

    // memories
    logic signed [NEED_W-1:0]        need_mem_reg [mwcs_pkg::ALPHABET];
    logic [mwcs_pkg::ALPHABET-1:0]   need_vld_reg;
    logic [mwcs_pkg::SYM_W-1:0]      text_mem_reg [mwcs_pkg::MAX_TEXT];

    // registered read data
    logic signed [NEED_W-1:0]        need_q_reg;
    logic                            need_vld_q_reg;
    logic [mwcs_pkg::SYM_W-1:0]      text_q_reg;

    // item and job state
    logic                            item_func_reg;
    logic [ALPHA_W-1:0]              item_sym_reg;
    logic                            item_last_reg;
    logic                            item_stored_reg;
    logic [ALPHA_W-1:0]              out_sym_reg;
    logic [LEN_W-1:0]                left_reg;
    logic [LEN_W-1:0]                right_reg;
    logic [LEN_W-1:0]                missing_reg;
    logic [POS_W-1:0]                best_start_reg;
    logic [LEN_W-1:0]                best_len_reg;
    logic                            lost_reg;

    logic                            m_tvalid_reg;
    logic [mwcs_pkg::M_DATA_W-1:0]   m_tdata_reg;

    logic [ALPHA_W-1:0]              in_sym;
    logic [ALPHA_W-1:0]              need_rd_addr;
    logic                            need_rd_en;
    logic [ALPHA_W-1:0]              need_wr_addr;
    logic signed [NEED_W-1:0]        need_wr_data;
    logic                            need_wr_en;
    logic signed [NEED_W-1:0]        need_val;
    logic [LEN_W-1:0]                win_len;
    logic                            found;
    logic [mwcs_pkg::M_DATA_W-1:0]   result;

    // alphabet is a power of two, so the modulo is the low bits
    assign in_sym   = s_tdata[ALPHA_W-1:0];
    assign need_val = need_vld_q_reg ? need_q_reg : '0;
    assign win_len  = right_reg - left_reg;

    assign need_rd_en   = cmd.latch_item || cmd.sh_need_rd;
    assign need_rd_addr = cmd.sh_need_rd ? text_q_reg[ALPHA_W-1:0] : in_sym;
    assign need_wr_en   = cmd.pat_inc || cmd.txt_dec || cmd.sh_wr;
    assign need_wr_addr = cmd.sh_wr ? out_sym_reg : item_sym_reg;
    assign need_wr_data = cmd.txt_dec ? (need_val - NEED_W'(1)) : (need_val + NEED_W'(1));

    always_ff @(posedge aclk) begin
        if (need_wr_en) begin
            need_mem_reg[need_wr_addr] <= need_wr_data;
        end
        if (need_rd_en) begin
            need_q_reg <= need_mem_reg[need_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_vld_reg   <= '0;
            need_vld_q_reg <= 1'b0;
        end else begin
            if (need_rd_en) begin
                need_vld_q_reg <= need_vld_reg[need_rd_addr];
            end
            if (cmd.finish) begin
                need_vld_reg <= '0;
            end else if (need_wr_en) begin
                need_vld_reg[need_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_text) begin
            text_mem_reg[right_reg[POS_W-1:0]] <= s_tdata[mwcs_pkg::SYM_W-1:0];
        end
        if (cmd.sh_txt_rd) begin
            text_q_reg <= text_mem_reg[left_reg[POS_W-1:0]];
        end
    end

    // payload of the current item
    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            item_func_reg   <= s_tuser;
            item_sym_reg    <= in_sym;
            item_last_reg   <= s_tlast;
            item_stored_reg <= cmd.store_text;
        end
        if (cmd.sh_need_rd) begin
            out_sym_reg <= text_q_reg[ALPHA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            left_reg       <= '0;
            right_reg      <= '0;
            missing_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= mwcs_pkg::LEN_NONE;
            lost_reg       <= 1'b0;
        end else begin
            if (cmd.store_text) begin
                right_reg <= right_reg + LEN_W'(1);
            end
            if (cmd.set_lost) begin
                lost_reg <= 1'b1;
            end
            if (cmd.pat_inc) begin
                missing_reg <= missing_reg + LEN_W'(1);
            end
            if (cmd.txt_dec && (need_val > 0)) begin
                missing_reg <= missing_reg - LEN_W'(1);
            end
            if (cmd.sh_txt_rd && (win_len < best_len_reg)) begin
                best_len_reg   <= win_len;
                best_start_reg <= left_reg[POS_W-1:0];
            end
            if (cmd.sh_wr) begin
                left_reg <= left_reg + LEN_W'(1);
                if (need_val >= 0) begin
                    missing_reg <= missing_reg + LEN_W'(1);
                end
            end
        end
    end

    // result register
    assign found = (best_len_reg != mwcs_pkg::LEN_NONE);

    always_comb begin
        result = '0;
        result[mwcs_pkg::OUT_FOUND_LSB] = found;
        result[mwcs_pkg::OUT_START_LSB +: POS_W] = found ? best_start_reg : '0;
        result[mwcs_pkg::OUT_LEN_LSB +: LEN_W]   = found ? best_len_reg : '0;
        result[mwcs_pkg::OUT_OVF_LSB] = lost_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        status              = '0;
        status.room         = (right_reg < LEN_W'(mwcs_pkg::MAX_TEXT));
        status.item_func    = item_func_reg;
        status.item_last    = item_last_reg;
        status.item_stored  = item_stored_reg;
        status.pattern_ok   = (right_reg == '0) && !lost_reg &&
                              (missing_reg < LEN_W'(mwcs_pkg::MAX_TEXT + 1));
        status.missing_zero = (missing_reg == '0);
        status.dec_covers   = (missing_reg == LEN_W'(1)) && (need_val > 0) &&
                              (left_reg < right_reg);
        status.sh_continue  = (need_val < 0) && ((left_reg + LEN_W'(1)) < right_reg);
        status.out_free     = !m_tvalid_reg || m_tready;
    end

endmodule

`default_nettype wire

@@ rtl/core/min_window_cover_search_core.sv @@
// Steps: a pattern symbol passes the idle and update states; a text symbol passes them too,
//   then for each left-edge advance the states that read the text store, read the need
//   count and write the need count. After the last text symbol a finish state loads the
//   result register, and waits there while the previous result still waits on m_tready.
// Throughput: one item in flight; s_tready is high only between items.
// Reset: aresetn (synchronous, active low) clears the controller, the window state and
//   the need-count valid bits at once; the text store is not cleared and needs no pass.
`default_nettype none

module min_window_cover_search_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input channel
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [mwcs_pkg::S_DATA_W-1:0]     s_tdata,   // [6:0] symbol, [7] zero
    input  wire                               s_tuser,   // [0] func: 0 pattern, 1 text
    input  wire                               s_tlast,   // last text symbol of the job
    // result channel
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [mwcs_pkg::M_DATA_W-1:0]     m_tdata    // [0] found, [10:1] window_start,
                                                         // [21:11] window_length,
                                                         // [22] overflow, [23] zero
);

    mwcs_pkg::mwcs_cmd_t    cmd;
    mwcs_pkg::mwcs_status_t status;

    // sequencer: one state per memory step
    mwcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // need counts, text store, window edges, best window and result register
    mwcs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    // every transfer needs at least the update cycle before the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // a not-found result carries zero start and length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[mwcs_pkg::OUT_FOUND_LSB]) |->
            (m_tdata[mwcs_pkg::OUT_OVF_LSB-1:mwcs_pkg::OUT_START_LSB] == '0))
        else $error("not-found result with nonzero window");

    // a found window is non-empty and fits the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[mwcs_pkg::OUT_FOUND_LSB]) |->
            ((m_tdata[mwcs_pkg::OUT_LEN_LSB +: mwcs_pkg::LEN_W] != '0) &&
             (m_tdata[mwcs_pkg::OUT_LEN_LSB +: mwcs_pkg::LEN_W] <=
              mwcs_pkg::LEN_W'(mwcs_pkg::MAX_TEXT))))
        else $error("found window length out of range");

endmodule

`default_nettype wire

@@ tb/sv/tb_min_window_cover_search_core.sv @@
`timescale 1ns / 1ps

module tb_min_window_cover_search_core;

    import mwcs_pkg::*;

    // run length guard, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_ITEMS = 680;
    localparam int unsigned NO_WINDOW    = 32'hFFFF_FFFF;

    // receiver stall patterns
    typedef enum int unsigned {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // one input transfer: func on tuser, symbol in tdata, last on tlast
    typedef struct packed {
        logic       func;
        logic [6:0] symbol;
        logic       last;
    } cover_item_t;

    // one result transfer, fields as carried in m_tdata
    typedef struct packed {
        logic        found;
        logic [9:0]  start;
        logic [10:0] length;
        logic        overflow;
    } cover_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    cover_item_t   pending_items[$];     // items queued for the input driver
    cover_result_t expected_results[$];  // predicted results, oldest first
    cover_result_t want;

    bit          item_in_hand;
    bit          sender_steady;          // no gaps between transfers
    int unsigned rx_hold_request;        // long receiver hold-off, in cycles
    int unsigned items_sent;
    int unsigned fail_count;
    int unsigned cycle_count;

    // predictor state
    int          need_cnt[ALPHABET];
    logic [6:0]  text_mem[MAX_TEXT];
    int unsigned win_left;
    int unsigned win_right;
    int unsigned missing_cnt;
    int unsigned best_pos;
    int unsigned best_len;
    bit          text_lost;

    min_window_cover_search_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("min_window_cover_search_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_cover_job();
        foreach (need_cnt[i]) need_cnt[i] = 0;
        win_left    = 0;
        win_right   = 0;
        missing_cnt = 0;
        best_pos    = 0;
        best_len    = NO_WINDOW;
        text_lost   = 1'b0;
    endfunction

    // Apply one accepted transfer; queue a result when the job ends.
    function automatic void predict_cover(cover_item_t it);
        int unsigned   pos;
        int unsigned   span;
        int unsigned   sym;
        int unsigned   out_sym;
        cover_result_t res;
        sym = it.symbol;
        if (it.func == FUNC_PATTERN) begin
            // pattern only counts before any text, and saturates one past depth
            if (win_right == 0 && !text_lost && missing_cnt < MAX_TEXT + 1) begin
                need_cnt[sym]++;
                missing_cnt++;
            end
            return;
        end
        if (win_right >= MAX_TEXT) begin
            text_lost = 1'b1;      // buffer full, symbol dropped
        end else begin
            pos           = win_right;
            text_mem[pos] = it.symbol;
            win_right     = pos + 1;
            if (missing_cnt != 0) begin
                need_cnt[sym]--;
                if (need_cnt[sym] >= 0) missing_cnt--;
                // shrink from the left while the window still covers
                while (missing_cnt == 0 && win_left <= pos) begin
                    span    = pos - win_left + 1;
                    out_sym = text_mem[win_left];
                    if (span < best_len) begin
                        best_len = span;
                        best_pos = win_left;
                    end
                    need_cnt[out_sym]++;
                    if (need_cnt[out_sym] > 0) missing_cnt++;
                    win_left++;
                end
            end
        end
        if (it.last) begin
            res.found    = (best_len != NO_WINDOW);
            res.start    = res.found ? best_pos[9:0] : 10'd0;
            res.length   = res.found ? best_len[10:0] : 11'd0;
            res.overflow = text_lost;
            expected_results.push_back(res);
            clear_cover_job();
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------

    initial begin : input_driver
        cover_item_t cur;
        int unsigned gap_left;
        int unsigned burst_left;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        item_in_hand = 1'b0;
        gap_left     = 0;
        burst_left   = 1;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (gap_left != 0 || pending_items.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                cur          = pending_items.pop_front();
                item_in_hand = 1'b1;
                s_tvalid    <= 1'b1;
                s_tdata     <= {1'b0, cur.symbol};
                s_tuser     <= cur.func;
                s_tlast     <= cur.last;
                // hold the transfer until the block takes it
                do @(posedge aclk); while (!s_tready);
                predict_cover(cur);
                item_in_hand = 1'b0;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    if (sender_steady || $urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: changing stall patterns, plus requested hold-offs
    // ------------------------------------------------------------------

    initial begin : result_receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned phase;
        m_tready  = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            phase++;
            if (rx_hold_request != 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= ($urandom_range(0, 2) != 0);
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_tready <= ((phase % 5) < 2);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    task automatic check_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual m_tdata 0x%h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("found", want.found, m_tdata[OUT_FOUND_LSB]);
                check_field("window_start", want.start, m_tdata[OUT_START_LSB +: POS_W]);
                check_field("window_length", want.length, m_tdata[OUT_LEN_LSB +: LEN_W]);
                check_field("overflow", want.overflow, m_tdata[OUT_OVF_LSB]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------

    task automatic send_item(input logic func, input logic [6:0] sym, input logic last);
        while (pending_items.size() >= 2) @(negedge aclk);
        pending_items.push_back('{func, sym, last});
        items_sent++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || item_in_hand || expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // lowest and highest symbol codes, window spanning the whole text
    task automatic test_symbol_extremes();
        send_item(FUNC_PATTERN, 7'h00, 1'b0);
        send_item(FUNC_PATTERN, 7'h7F, 1'b0);
        send_item(FUNC_TEXT,    7'h7F, 1'b0);
        send_item(FUNC_TEXT,    7'h2A, 1'b0);
        send_item(FUNC_TEXT,    7'h00, 1'b1);
    endtask

    // no pattern at all: not found
    task automatic test_empty_pattern();
        send_item(FUNC_TEXT, 7'h41, 1'b0);
        send_item(FUNC_TEXT, 7'h42, 1'b1);
    endtask

    // repeated pattern symbols must all be covered
    task automatic test_repeated_symbols();
        send_item(FUNC_PATTERN, 7'h61, 1'b0);
        send_item(FUNC_PATTERN, 7'h61, 1'b0);
        send_item(FUNC_PATTERN, 7'h62, 1'b0);
        send_item(FUNC_TEXT,    7'h61, 1'b0);
        send_item(FUNC_TEXT,    7'h62, 1'b0);
        send_item(FUNC_TEXT,    7'h63, 1'b0);
        send_item(FUNC_TEXT,    7'h61, 1'b1);
    endtask

    // pattern longer than the text: not found
    task automatic test_text_too_short();
        send_item(FUNC_PATTERN, 7'h61, 1'b0);
        send_item(FUNC_PATTERN, 7'h62, 1'b0);
        send_item(FUNC_TEXT,    7'h61, 1'b1);
    endtask

    // last on a pattern symbol and pattern after text are both ignored
    task automatic test_ignored_items();
        send_item(FUNC_PATTERN, 7'h78, 1'b1);
        send_item(FUNC_TEXT,    7'h79, 1'b0);
        send_item(FUNC_PATTERN, 7'h79, 1'b0);
        send_item(FUNC_TEXT,    7'h78, 1'b1);
    endtask

    // two equally short windows: the earlier one is kept
    task automatic test_earliest_window();
        send_item(FUNC_PATTERN, 7'h61, 1'b0);
        send_item(FUNC_TEXT,    7'h62, 1'b0);
        send_item(FUNC_TEXT,    7'h61, 1'b0);
        send_item(FUNC_TEXT,    7'h61, 1'b1);
    endtask

    // window spanning the full buffer, then dropped text including the last
    task automatic test_text_overflow();
        logic [6:0] sym;
        send_item(FUNC_PATTERN, 7'h61, 1'b0);
        send_item(FUNC_PATTERN, 7'h62, 1'b0);
        for (int i = 0; i < MAX_TEXT + 4; i++) begin
            sym = 7'($urandom_range(0, 127));
            if (sym == 7'h61 || sym == 7'h62) sym = 7'h63;
            if (i == 0) sym = 7'h61;
            if (i == MAX_TEXT - 1) sym = 7'h62;
            send_item(FUNC_TEXT, sym, i == MAX_TEXT + 3);
        end
    endtask

    // receiver holds off while several jobs are offered: input must stall
    task automatic test_output_backpressure();
        wait_idle();
        rx_hold_request = 400;
        sender_steady   = 1'b1;
        for (int j = 0; j < 4; j++) begin
            send_item(FUNC_PATTERN, 7'(j + 7'h30), 1'b0);
            send_item(FUNC_TEXT,    7'h20,         1'b0);
            send_item(FUNC_TEXT,    7'(j + 7'h30), 1'b1);
        end
        wait_idle();
        sender_steady = 1'b0;
    endtask

    // random jobs, mostly well-formed over a small random alphabet
    task automatic test_random_jobs();
        logic [6:0]  letters[8];
        int unsigned first_item;
        int unsigned kind;
        int unsigned n_letters;
        int unsigned pat_len;
        int unsigned txt_len;
        logic [6:0]  sym;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            kind          = $urandom_range(0, 11);
            sender_steady = ($urandom_range(0, 4) == 0);
            n_letters     = $urandom_range(1, 8);
            foreach (letters[i]) letters[i] = 7'($urandom_range(0, 127));
            pat_len = (kind == 0) ? 0 : $urandom_range(1, 5);
            txt_len = $urandom_range(1, (kind == 1) ? 120 : 24);
            // kind 2: stray last flags on pattern symbols
            for (int i = 0; i < pat_len; i++)
                send_item(FUNC_PATTERN, letters[$urandom_range(0, n_letters - 1)],
                          kind == 2 && $urandom_range(0, 2) == 0);
            for (int i = 0; i < txt_len; i++) begin
                sym = letters[$urandom_range(0, n_letters - 1)];
                // kind 3: noise symbols over the full code range
                if (kind == 3 && $urandom_range(0, 3) == 0) sym = 7'($urandom_range(0, 127));
                // kind 4: pattern symbols mixed into the text
                if (kind == 4 && $urandom_range(0, 4) == 0)
                    send_item(FUNC_PATTERN, letters[$urandom_range(0, n_letters - 1)],
                              1'($urandom_range(0, 1)));
                send_item(FUNC_TEXT, sym, i == txt_len - 1);
            end
        end
        sender_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn         = 1'b0;
        sender_steady   = 1'b0;
        rx_hold_request = 0;
        items_sent      = 0;
        fail_count      = 0;
        cycle_count     = 0;
        clear_cover_job();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_symbol_extremes();
        test_empty_pattern();
        test_repeated_symbols();
        test_text_too_short();
        test_ignored_items();
        test_earliest_window();
        test_output_backpressure();
        test_text_overflow();
        test_random_jobs();

        // drain, then give the block time to show any stray transfer
        wait_idle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("min_window_cover_search_core test passed");
        end else begin
            $display("min_window_cover_search_core test failed");
        end
        $finish;
    end

endmodule
